/* rtl/gtf_pkg.sv */
// ----------------------------------------------------------------------------
// gtf_pkg
// Shared types and sizes for the grouped team queue.
// ----------------------------------------------------------------------------
`default_nettype none

package gtf_pkg;

  localparam int MEMBER_BITS    = 10;
  localparam int MEMBER_DEPTH   = 1 << MEMBER_BITS;
  localparam int TEAM_BITS      = 4;
  localparam int TEAM_COUNT     = 1 << TEAM_BITS;
  localparam int ENTRY_BITS     = TEAM_BITS + 1;
  localparam int SLOT_BITS      = 6;
  localparam int QUEUE_CAPACITY = 1 << SLOT_BITS;
  localparam int OCC_BITS       = SLOT_BITS + 1;

  typedef enum logic [1:0] {
    CMD_MAP     = 2'd0,
    CMD_ENQUEUE = 2'd1,
    CMD_DEQUEUE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNMAPPED = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                   command;
    logic [MEMBER_BITS-1:0] member_id;
    logic [TEAM_BITS-1:0]   team_id;
  } item_t;

endpackage

`default_nettype wire

/* rtl/gtf_if.sv */
// ----------------------------------------------------------------------------
// gtf_cmd_if / gtf_rsp_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtf_cmd_if;
  import gtf_pkg::*;
  logic                   valid;
  logic                   ready;
  cmd_t                   command;
  logic [MEMBER_BITS-1:0] member_id;
  logic [TEAM_BITS-1:0]   team_id;

  modport source (output valid, command, member_id, team_id, input ready);
  modport sink   (input valid, command, member_id, team_id, output ready);
endinterface

interface gtf_rsp_if;
  import gtf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [MEMBER_BITS-1:0] out_member;
  status_t                status;
  logic [OCC_BITS-1:0]    occupancy;

  modport source (output valid, out_member, status, occupancy, input ready);
  modport sink   (input valid, out_member, status, occupancy, output ready);
endinterface

`default_nettype wire

/* rtl/gtf_front.sv */
// ----------------------------------------------------------------------------
// gtf_front
// Accepts commands and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  gtf_cmd_if.sink            cmd,
  input  wire logic          busy,
  output gtf_pkg::item_t     q_item,
  output logic               q_valid,
  input  wire logic          q_pop
);
  import gtf_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign cmd.ready = !busy && (count != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != 2'd0);
  assign q_item    = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{command: cmd.command, member_id: cmd.member_id,
                         team_id: cmd.team_id};
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push)  wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/gtf_back.sv */
// ----------------------------------------------------------------------------
// gtf_back
// Executes one command at a time: a read step on the tables and node pool,
// then a commit step that updates the lists and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire gtf_pkg::item_t q_item,
  input  wire logic          q_valid,
  output logic               q_pop,
  output logic               busy,
  gtf_rsp_if.source          rsp
);
  import gtf_pkg::*;

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC} state_t;

  state_t                  state;
  logic [MEMBER_BITS-1:0]  init_addr;
  item_t                   cur;

  // memories
  logic [ENTRY_BITS-1:0]   tbl_mem [MEMBER_DEPTH];
  logic [MEMBER_BITS-1:0]  nm_mem  [QUEUE_CAPACITY];
  logic [SLOT_BITS-1:0]    nn_mem  [QUEUE_CAPACITY];
  logic [SLOT_BITS-1:0]    stk_mem [QUEUE_CAPACITY];
  logic [ENTRY_BITS-1:0]   tbl_rd;
  logic [MEMBER_BITS-1:0]  nm_rd;
  logic [SLOT_BITS-1:0]    nn_rd;
  logic [SLOT_BITS-1:0]    stk_rd;

  // team state
  logic [OCC_BITS-1:0]     team_cnt  [TEAM_COUNT];
  logic [SLOT_BITS-1:0]    team_head [TEAM_COUNT];
  logic [SLOT_BITS-1:0]    team_tail [TEAM_COUNT];
  logic [TEAM_BITS-1:0]    team_order [TEAM_COUNT];
  logic [TEAM_BITS-1:0]    order_head;
  logic [TEAM_BITS-1:0]    order_tail;
  logic [OCC_BITS-1:0]     total;
  logic [OCC_BITS-1:0]     free_cnt;   // freed slots on the stack
  logic [OCC_BITS-1:0]     fresh;      // slots never handed out since clear

  logic                    out_valid;
  logic [MEMBER_BITS-1:0]  out_member;
  status_t                 out_status;
  logic [OCC_BITS-1:0]     out_occ;

  logic                    commit;
  logic [ENTRY_BITS-1:0]   entry_m1;
  logic [TEAM_BITS-1:0]    enq_team;
  logic [TEAM_BITS-1:0]    deq_team;
  logic [TEAM_BITS-1:0]    team_sel;
  logic [SLOT_BITS-1:0]    deq_slot;
  logic [SLOT_BITS-1:0]    alloc_slot;
  logic [OCC_BITS-1:0]     stk_top;
  logic                    enq_ok;
  logic                    deq_ok;
  status_t                 status_c;
  logic [MEMBER_BITS-1:0]  result_c;
  logic [OCC_BITS-1:0]     total_next;
  logic                    tbl_we;
  logic [MEMBER_BITS-1:0]  tbl_wa;
  logic [ENTRY_BITS-1:0]   tbl_wd;

  assign busy     = (state == S_INIT);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign commit   = (state == S_EXEC) && (!out_valid || rsp.ready);

  assign rsp.valid      = out_valid;
  assign rsp.out_member = out_member;
  assign rsp.status     = out_status;
  assign rsp.occupancy  = out_occ;

  // classify and evaluate the current command
  always_comb begin
    entry_m1   = tbl_rd - ENTRY_BITS'(1);
    enq_team   = entry_m1[TEAM_BITS-1:0];
    deq_team   = team_order[order_head];
    deq_slot   = team_head[deq_team];
    team_sel   = (cur.command == CMD_ENQUEUE) ? enq_team : deq_team;
    alloc_slot = (free_cnt != '0) ? stk_rd : fresh[SLOT_BITS-1:0];
    stk_top    = free_cnt - OCC_BITS'(1);
    enq_ok     = 1'b0;
    deq_ok     = 1'b0;
    status_c   = ST_OK;
    result_c   = '0;
    total_next = total;
    case (cur.command)
      CMD_ENQUEUE: begin
        if (tbl_rd == '0) begin
          status_c = ST_UNMAPPED;
        end else if (total == OCC_BITS'(QUEUE_CAPACITY)) begin
          status_c = ST_FULL;
        end else begin
          enq_ok     = 1'b1;
          total_next = total + OCC_BITS'(1);
        end
      end
      CMD_DEQUEUE: begin
        if (total == '0) begin
          status_c = ST_EMPTY;
        end else begin
          deq_ok     = 1'b1;
          result_c   = nm_rd;
          total_next = total - OCC_BITS'(1);
        end
      end
      CMD_CLEAR: total_next = '0;
      default:   total_next = total;
    endcase
  end

  // member-to-team table: swept to unmapped after reset
  always_comb begin
    tbl_we = busy || (commit && cur.command == CMD_MAP);
    tbl_wa = busy ? init_addr : cur.member_id;
    tbl_wd = busy ? '0 : ({1'b0, cur.team_id} + ENTRY_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (q_pop)  tbl_rd <= tbl_mem[q_item.member_id];
  end

  // node pool
  always_ff @(posedge clk) begin
    if (commit && enq_ok) nm_mem[alloc_slot] <= cur.member_id;
    if (q_pop)            nm_rd <= nm_mem[deq_slot];
  end

  always_ff @(posedge clk) begin
    if (commit && enq_ok && team_cnt[team_sel] != '0) begin
      nn_mem[team_tail[team_sel]] <= alloc_slot;
    end
    if (q_pop) nn_rd <= nn_mem[deq_slot];
  end

  // free-slot stack
  always_ff @(posedge clk) begin
    if (commit && deq_ok) stk_mem[free_cnt[SLOT_BITS-1:0]] <= deq_slot;
    if (q_pop)            stk_rd <= stk_mem[stk_top[SLOT_BITS-1:0]];
  end

  // sequencer, list pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_addr  <= '0;
      out_valid  <= 1'b0;
      total      <= '0;
      free_cnt   <= '0;
      fresh      <= '0;
      order_head <= '0;
      order_tail <= '0;
      for (int i = 0; i < TEAM_COUNT; i++) team_cnt[i] <= '0;
    end else begin
      // result taken and no new one loaded this cycle
      if (rsp.valid && rsp.ready && !commit) out_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          init_addr <= init_addr + MEMBER_BITS'(1);
          if (init_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state      <= S_IDLE;
            out_valid  <= 1'b1;
            out_member <= result_c;
            out_status <= status_c;
            out_occ    <= total_next;
            total      <= total_next;
            if (enq_ok) begin
              if (team_cnt[team_sel] == '0) begin
                team_head[team_sel]   <= alloc_slot;
                team_order[order_tail] <= team_sel;
                order_tail            <= order_tail + TEAM_BITS'(1);
              end
              team_tail[team_sel] <= alloc_slot;
              team_cnt[team_sel]  <= team_cnt[team_sel] + OCC_BITS'(1);
              if (free_cnt != '0) free_cnt <= stk_top;
              else                fresh    <= fresh + OCC_BITS'(1);
            end
            if (deq_ok) begin
              if (team_cnt[team_sel] > OCC_BITS'(1)) begin
                team_head[team_sel] <= nn_rd;
                team_cnt[team_sel]  <= team_cnt[team_sel] - OCC_BITS'(1);
              end else begin
                team_cnt[team_sel] <= '0;
                order_head         <= order_head + TEAM_BITS'(1);
              end
              free_cnt <= free_cnt + OCC_BITS'(1);
            end
            if (cur.command == CMD_CLEAR) begin
              free_cnt   <= '0;
              fresh      <= '0;
              order_head <= '0;
              order_tail <= '0;
              for (int i = 0; i < TEAM_COUNT; i++) team_cnt[i] <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/grouped_team_fifo_top.sv */
// ----------------------------------------------------------------------------
// grouped_team_fifo_top
// Team queue: members join behind the last queued member of their team.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-entry member-to-team table to
// unmapped, one entry per cycle, and takes no command until the sweep ends.
// Each command then runs in the execution engine as a read of the team table
// and node pool memories and a commit of the list updates, which waits while
// the result register holds an untaken result; the next command waits for the
// commit. A two-entry command queue and a result register let both channels
// stall independently. Every command returns exactly one result.
`default_nettype none

module grouped_team_fifo_top (
  input  wire logic clk,
  input  wire logic rst,
  gtf_cmd_if.sink   cmd,
  gtf_rsp_if.source rsp
);
  import gtf_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  logic  busy;

  gtf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .busy    (busy),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  gtf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .busy    (busy),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire
